### rtl/core/wmd_pkg.sv
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared widths, reset values and status codes of the window motion detector.
// ----------------------------------------------------------------------------
package wmd_pkg;

    // Q15.8 sample and its parts
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 8;
    localparam int WHOLE_W  = SAMPLE_W - FRAC_W;

    // threshold register
    localparam int             THRESH_W     = 16;
    localparam logic [15:0]    THRESH_RESET = 16'd10;

    // default ring window length
    localparam int DEFAULT_WINDOW_LENGTH = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WHOLE_W-1:0]  t_whole;

    // detector status codes
    typedef enum logic [1:0] {
        ST_RESET   = 2'd0,
        ST_TRIGGER = 2'd1,
        ST_ADDUP   = 2'd2,
        ST_FINISH  = 2'd3
    } t_status;

endpackage

### rtl/core/wmd_stream_if.sv
// ----------------------------------------------------------------------------
// wmd_stream_if
// Valid/ready channels of the detector: sample requests in, results out.
// ----------------------------------------------------------------------------
interface wmd_in_if;
    import wmd_pkg::*;

    logic    valid;
    logic    ready;
    logic    operation;
    t_sample sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface wmd_out_if;
    import wmd_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_sample average;

    modport source (output valid, output status, output average, input ready);
    modport sink   (input valid, input status, input average, output ready);
endinterface

### rtl/core/wmd_ram.sv
// ----------------------------------------------------------------------------
// wmd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/window_motion_detector.sv
// ----------------------------------------------------------------------------
// window_motion_detector
// Still/moving judge over a ring window of Q15.8 samples and its mean.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+-----------------------------
//  i_in      | in  | valid / ready         | operation, sample (Q15.8)
//  o_out     | out | valid / ready         | status, average (Q15.8)
//  i_cfg_*   | in  | i_cfg_valid / o_cfg_ready | trigger threshold
//
//  One request per cycle sustained while o_out is not held; the result of a
//  request passes stage 1, stage 2, stage 3 and the result register before it
//  is presented. The rate is set by the judge stage, which updates the window
//  sum while the window RAM read for the following request is issued from its decision.
//  Reset is synchronous; window entries are qualified by per-entry valid
//  bits, so there is no clearing pass. While a result waits on o_out the
//  whole pipeline holds and i_in.ready is low.
// ----------------------------------------------------------------------------
module window_motion_detector #(
    parameter int WINDOW_LENGTH = wmd_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wmd_in_if.sink                        i_in,
    wmd_out_if.source                     o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wmd_pkg::THRESH_W-1:0]  i_cfg_data
);
    import wmd_pkg::*;

    // ring index / remainder width and counter widths
    localparam int RW    = $clog2(WINDOW_LENGTH);
    localparam int EW    = SAMPLE_W + RW;
    localparam int FillW = $clog2(WINDOW_LENGTH + 2);
    localparam int MovW  = $clog2(4 * WINDOW_LENGTH + 2);
    localparam int CalmW = $clog2(WINDOW_LENGTH + 1);

    localparam logic [RW-1:0]    RingLast = RW'(WINDOW_LENGTH - 1);
    localparam logic [FillW-1:0] FillMax  = FillW'(WINDOW_LENGTH);
    localparam logic [MovW-1:0]  MovTwo   = MovW'(2 * WINDOW_LENGTH);
    localparam logic [MovW-1:0]  MovThree = MovW'(3 * WINDOW_LENGTH);
    localparam logic [MovW-1:0]  MovFour  = MovW'(4 * WINDOW_LENGTH);
    localparam logic [CalmW-1:0] CalmMax  = CalmW'(WINDOW_LENGTH);

    // exact reciprocal for floor(mag / W), mag < 2^SAMPLE_W
    localparam int RecipShift = SAMPLE_W + RW;
    localparam logic [SAMPLE_W:0] RecipMul = (SAMPLE_W + 1)'(
        ((64'd1 << RecipShift) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic s_adv;
    logic r_out_valid;

    assign s_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = s_adv;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // stage 1: magnitude times reciprocal
    // ------------------------------------------------------------------
    logic                    r_s1_valid;
    logic                    r_s1_op;
    t_sample                 r_s1_sample;
    logic                    s1_neg;
    logic [SAMPLE_W-1:0]     s1_mag;
    logic [2*SAMPLE_W:0]     s1_prod;
    logic [SAMPLE_W-1:0]     s1_quot;

    assign s1_neg  = r_s1_sample[SAMPLE_W-1];
    assign s1_mag  = s1_neg ? SAMPLE_W'(-r_s1_sample) : SAMPLE_W'(r_s1_sample);
    assign s1_prod = (2 * SAMPLE_W + 1)'(s1_mag) * (2 * SAMPLE_W + 1)'(RecipMul);
    assign s1_quot = SAMPLE_W'(s1_prod >> RecipShift);

    // ------------------------------------------------------------------
    // stage 2: remainder, floor split and whole part of the sample
    // ------------------------------------------------------------------
    logic                    r_s2_valid;
    logic                    r_s2_op;
    logic                    r_s2_neg;
    t_sample                 r_s2_sample;
    logic [SAMPLE_W-1:0]     r_s2_mag;
    logic [SAMPLE_W-1:0]     r_s2_quot;
    logic [SAMPLE_W:0]       s2_back;
    logic [SAMPLE_W:0]       s2_rem_full;
    logic [RW-1:0]           s2_rem;
    t_sample                 s2_q;
    logic [RW-1:0]           s2_r;
    logic [SAMPLE_W-1:0]     s2_round;
    t_whole                  s2_whole;

    assign s2_back     = {1'b0, r_s2_quot} * (SAMPLE_W + 1)'(WINDOW_LENGTH);
    assign s2_rem_full = {1'b0, r_s2_mag} - s2_back;
    assign s2_rem      = s2_rem_full[RW-1:0];

    // negative samples: floor quotient and non-negative remainder
    always_comb begin
        if (!r_s2_neg) begin
            s2_q = t_sample'(r_s2_quot);
            s2_r = s2_rem;
        end else if (s2_rem == '0) begin
            s2_q = t_sample'(-r_s2_quot);
            s2_r = '0;
        end else begin
            s2_q = t_sample'(~r_s2_quot);
            s2_r = RW'((RW + 1)'(WINDOW_LENGTH) - {1'b0, s2_rem});
        end
    end

    // whole part, truncated toward zero
    assign s2_round = SAMPLE_W'(r_s2_sample) + {{WHOLE_W{1'b0}}, {FRAC_W{r_s2_neg}}};
    assign s2_whole = t_whole'(s2_round[SAMPLE_W-1:FRAC_W]);

    // ------------------------------------------------------------------
    // stage 3: judge and window read-modify-write
    // ------------------------------------------------------------------
    logic                    r_s3_valid;
    logic                    r_s3_op;
    t_sample                 r_s3_q;
    logic [RW-1:0]           r_s3_r;
    t_whole                  r_s3_whole;

    // detector state
    logic [THRESH_W-1:0]     r_thr;
    t_sample                 r_q;
    logic [RW-1:0]           r_r;
    t_whole                  r_mean_whole;
    logic [RW-1:0]           r_ring;
    t_status                 r_status;
    logic [FillW-1:0]        r_fill;
    logic [MovW-1:0]         r_moving;
    logic [CalmW-1:0]        r_calm;
    logic [WINDOW_LENGTH-1:0] r_ent_valid;
    logic [RW-1:0]           r_rd_addr;

    logic [RW-1:0]           n_ring;
    t_status                 n_status;
    logic [FillW-1:0]        n_fill;
    logic [MovW-1:0]         n_moving;
    logic [CalmW-1:0]        n_calm;
    t_sample                 n_q;
    logic [RW-1:0]           n_r;
    t_sample                 n_mean;
    t_whole                  n_mean_whole;

    logic                    c_fire;
    logic                    do_upd;
    logic                    do_clear;
    logic [RW-1:0]           ring_adv;

    assign c_fire   = r_s3_valid && s_adv;
    assign ring_adv = (r_ring == RingLast) ? '0 : r_ring + RW'(1);

    // old entry, zero when not written since reset or the last clear
    logic [EW-1:0]           ram_rdata;
    logic                    ent_valid;
    t_sample                 old_q;
    logic [RW-1:0]           old_r;

    assign ent_valid = r_ent_valid[r_rd_addr];
    assign old_q     = ent_valid ? t_sample'(ram_rdata[EW-1 -: SAMPLE_W]) : '0;
    assign old_r     = ent_valid ? ram_rdata[RW-1:0] : '0;

    // absolute whole-part difference against the current mean
    logic signed [WHOLE_W:0] diff_s;
    logic [WHOLE_W:0]        diff_abs;
    logic                    diff_gt;
    logic                    diff_lt;

    assign diff_s   = {r_s3_whole[WHOLE_W-1], r_s3_whole}
                    - {r_mean_whole[WHOLE_W-1], r_mean_whole};
    assign diff_abs = diff_s[WHOLE_W] ? (WHOLE_W + 1)'(-diff_s) : (WHOLE_W + 1)'(diff_s);
    assign diff_gt  = diff_abs > {1'b0, r_thr};
    assign diff_lt  = diff_abs < {1'b0, r_thr};

    // judge decisions
    always_comb begin
        n_ring   = r_ring;
        n_status = r_status;
        n_fill   = r_fill;
        n_moving = r_moving;
        n_calm   = r_calm;
        do_upd   = 1'b0;
        do_clear = 1'b0;
        if (r_s3_valid) begin
            if (!r_s3_op) begin
                // still to moving
                if (r_fill > FillMax) begin
                    if (diff_gt) begin
                        n_status = ST_TRIGGER;
                        n_ring   = '0;
                    end else begin
                        do_upd = 1'b1;
                    end
                end else begin
                    n_fill = r_fill + FillW'(1);
                    do_upd = 1'b1;
                end
            end else if (r_moving < MovTwo) begin
                // moving to still, settling period
                n_moving = r_moving + MovW'(1);
            end else begin
                do_clear = (r_moving == MovThree);
                do_upd   = (r_moving > MovThree);
                if (r_moving > MovFour) begin
                    if (diff_lt) begin
                        n_status = ST_ADDUP;
                        if (r_calm < CalmMax) begin
                            n_calm = r_calm + CalmW'(1);
                        end
                    end
                    if (diff_gt) begin
                        n_status = ST_TRIGGER;
                        n_calm   = '0;
                    end
                end
                if (n_status == ST_ADDUP && n_calm >= CalmMax) begin
                    n_status = ST_FINISH;
                    n_moving = '0;
                    n_calm   = '0;
                end else if (r_moving <= MovFour) begin
                    n_moving = r_moving + MovW'(1);
                end
            end
            if (do_upd) begin
                n_ring = ring_adv;
            end
        end
    end

    // window sum kept as floor quotient and remainder by the window length
    logic signed [RW+1:0]       upd_rsum;
    logic signed [1:0]          upd_carry;
    logic [RW-1:0]              upd_r;
    logic signed [SAMPLE_W+1:0] upd_qsum;
    t_sample                    upd_q;

    assign upd_rsum = $signed({2'b00, r_r}) + $signed({2'b00, r_s3_r})
                    - $signed({2'b00, old_r});

    always_comb begin
        if (upd_rsum < 0) begin
            upd_carry = -2'sd1;
            upd_r     = RW'(upd_rsum + (RW + 2)'(WINDOW_LENGTH));
        end else if (upd_rsum >= $signed((RW + 2)'(WINDOW_LENGTH))) begin
            upd_carry = 2'sd1;
            upd_r     = RW'(upd_rsum - (RW + 2)'(WINDOW_LENGTH));
        end else begin
            upd_carry = 2'sd0;
            upd_r     = RW'(upd_rsum);
        end
    end

    assign upd_qsum = {{2{r_q[SAMPLE_W-1]}}, r_q} + {{2{r_s3_q[SAMPLE_W-1]}}, r_s3_q}
                    - {{2{old_q[SAMPLE_W-1]}}, old_q}
                    + {{SAMPLE_W{upd_carry[1]}}, upd_carry};
    assign upd_q    = t_sample'(upd_qsum[SAMPLE_W-1:0]);

    // next sum split
    always_comb begin
        if (do_clear) begin
            n_q = '0;
            n_r = '0;
        end else if (do_upd) begin
            n_q = upd_q;
            n_r = upd_r;
        end else begin
            n_q = r_q;
            n_r = r_r;
        end
    end

    // mean truncated toward zero and its whole part
    logic                n_mean_neg;
    logic [SAMPLE_W-1:0] n_mean_round;

    assign n_mean       = n_q + t_sample'((n_q < 0) && (n_r != '0));
    assign n_mean_neg   = n_mean[SAMPLE_W-1];
    assign n_mean_round = SAMPLE_W'(n_mean) + {{WHOLE_W{1'b0}}, {FRAC_W{n_mean_neg}}};
    assign n_mean_whole = t_whole'(n_mean_round[SAMPLE_W-1:FRAC_W]);

    // window RAM: entries hold the floor split of each sample
    wmd_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_LENGTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (c_fire && do_upd),
        .i_waddr (r_ring),
        .i_wdata ({r_s3_q, r_s3_r}),
        .i_re    (s_adv),
        .i_raddr (n_ring),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    // pipeline valids and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_s1_valid  <= i_in.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_s1_op     <= i_in.operation;
            r_s1_sample <= i_in.sample;
            r_s2_op     <= r_s1_op;
            r_s2_neg    <= s1_neg;
            r_s2_sample <= r_s1_sample;
            r_s2_mag    <= s1_mag;
            r_s2_quot   <= s1_quot;
            r_s3_op     <= r_s2_op;
            r_s3_q      <= s2_q;
            r_s3_r      <= s2_r;
            r_s3_whole  <= s2_whole;
            r_rd_addr   <= n_ring;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            o_out.status  <= n_status;
            o_out.average <= n_mean;
        end
    end

    assign o_out.valid = r_out_valid;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q          <= '0;
            r_r          <= '0;
            r_mean_whole <= '0;
            r_ring       <= '0;
            r_status     <= ST_RESET;
            r_fill       <= '0;
            r_moving     <= '0;
            r_calm       <= '0;
            r_ent_valid  <= '0;
        end else if (c_fire) begin
            r_q          <= n_q;
            r_r          <= n_r;
            r_mean_whole <= n_mean_whole;
            r_ring       <= n_ring;
            r_status     <= n_status;
            r_fill       <= n_fill;
            r_moving     <= n_moving;
            r_calm       <= n_calm;
            if (do_clear) begin
                r_ent_valid <= '0;
            end else if (do_upd) begin
                r_ent_valid[r_ring] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a window clear leaves no entry readable
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_fire && do_clear |=> r_ent_valid == '0)
        else $error("window entries still valid after clear");

    // a held pipeline leaves the detector state alone
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_adv |=> $stable(r_q) && $stable(r_r) && $stable(r_ring) && $stable(r_status))
        else $error("detector state changed during stall");

    // a still-to-moving request that skips the update is a trigger
    a_trigger_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_fire && !r_s3_op && !do_upd |=> r_ring == '0 && r_status == ST_TRIGGER)
        else $error("trigger did not rewind ring index");

    // counters stay within their saturation limits
    a_counter_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillMax + FillW'(1) && r_moving <= MovFour + MovW'(1)
        && r_calm <= CalmMax && r_ring <= RingLast)
        else $error("counter out of range");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for window_motion_detector. A short table of directed
// requests covers reset behavior, sample extremes, fill and trigger of the
// still-to-moving judge. It is followed by random runs of calm
// moving-to-still samples, still-to-moving samples with jumps, and full-range
// noise, under several trigger thresholds. Typed rows are checked against the
// table, the rest against an in-bench model of the window, its mean and the judge counters.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wmd_pkg::*;

    localparam int WIN = DEFAULT_WINDOW_LENGTH;

    // operation bit of a request
    localparam bit OP_STILL_TO_MOVING = 1'b0;
    localparam bit OP_MOVING_TO_STILL = 1'b1;

    typedef struct {
        t_status status;
        t_sample average;
    } t_judge_result;

    // one row of directed requests: repeated reps times
    typedef struct {
        bit          op;
        t_sample     smp;
        int unsigned reps;
        bit          typed;
        t_status     status;
        t_sample     average;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [THRESH_W-1:0] i_cfg_data;

    wmd_in_if  in_if ();
    wmd_out_if out_if ();

    window_motion_detector #(
        .WINDOW_LENGTH (WIN)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // detector model state
    t_sample             win_q8 [WIN];
    logic signed [27:0]  win_sum    = '0;
    int                  ring_pos   = 0;
    t_status             det_status = ST_RESET;
    int                  fill_cnt   = 0;
    int                  motion_cnt = 0;
    int                  calm_cnt   = 0;
    logic [THRESH_W-1:0] trig_thr   = THRESH_RESET;

    t_judge_result pending_results [$];
    int unsigned   fail_count = 0;
    bit            src_quiet  = 1'b0;
    bit            sink_quiet = 1'b0;

    t_stim_row           directed_rows [10];
    logic [THRESH_W-1:0] phase_thr [8];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // absolute difference of whole parts, sample against current mean
    function automatic longint whole_gap(t_sample smp);
        longint s;
        longint m;
        longint d;
        s = smp;
        m = win_sum;
        d = s / 256 - m / (WIN * 256);
        return (d < 0) ? -d : d;
    endfunction

    function automatic void slide_window(t_sample smp);
        int k;
        k = ring_pos % WIN;
        win_sum   = win_sum + smp - win_q8[k];
        win_q8[k] = smp;
        ring_pos  = (k + 1) % WIN;
    endfunction

    // one request through the selected judge; returns status and mean after it
    function automatic t_judge_result judge_sample(bit op, t_sample smp);
        t_judge_result r;
        longint        gap;
        longint        thr;
        longint        s;
        gap = whole_gap(smp);
        thr = trig_thr;
        if (op == OP_STILL_TO_MOVING) begin
            if (fill_cnt > WIN) begin
                if (gap > thr) begin
                    det_status = ST_TRIGGER;
                    ring_pos   = 0;
                end else begin
                    slide_window(smp);
                end
            end else begin
                fill_cnt++;
                slide_window(smp);
            end
        end else if (motion_cnt < 2 * WIN) begin
            motion_cnt++;
        end else begin
            // window dropped once, then refilled with fresh samples
            if (motion_cnt == 3 * WIN) begin
                foreach (win_q8[j]) win_q8[j] = '0;
                win_sum = '0;
            end
            if (motion_cnt > 3 * WIN)
                slide_window(smp);
            if (motion_cnt > 4 * WIN) begin
                if (gap < thr) begin
                    det_status = ST_ADDUP;
                    if (calm_cnt < WIN)
                        calm_cnt++;
                end
                if (gap > thr) begin
                    det_status = ST_TRIGGER;
                    calm_cnt   = 0;
                end
            end
            if (det_status == ST_ADDUP && calm_cnt >= WIN) begin
                det_status = ST_FINISH;
                motion_cnt = 0;
                calm_cnt   = 0;
            end else if (motion_cnt <= 4 * WIN) begin
                motion_cnt++;
            end
        end
        s = win_sum;
        r.status  = det_status;
        r.average = t_sample'(s / WIN);
        return r;
    endfunction

    // per-request wait, with occasional stretches of no waiting at all
    function automatic int unsigned draw_wait(inout bit quiet);
        if ($urandom_range(0, 63) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic push_sample(bit op, t_sample smp, bit typed, t_status st, t_sample avg);
        int unsigned   gap;
        t_judge_result want;
        gap = draw_wait(src_quiet);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.sample    <= smp;
        do @(posedge i_clk); while (!in_if.ready);
        want = judge_sample(op, smp);
        if (typed) begin
            want.status  = st;
            want.average = avg;
        end
        pending_results.push_back(want);
    endtask

    // let every result come back, then write the threshold
    task automatic drain_and_set(logic [THRESH_W-1:0] thr);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        trig_thr = thr;
    endtask

    // random runs: calm moving-to-still, still-to-moving with jumps, noise
    task automatic run_random(int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned spread;
        int          base;
        int          v;
        bit          op;
        t_sample     smp;
        sent = 0;
        while (sent < n_items) begin
            kind   = $urandom_range(0, 99);
            base   = int'($urandom_range(0, 60000)) - 30000;
            spread = (trig_thr > 60) ? 30 : trig_thr / 2;
            op     = OP_MOVING_TO_STILL;
            if (kind < 55) begin
                len = $urandom_range(60, 110);
            end else if (kind < 85) begin
                op  = OP_STILL_TO_MOVING;
                len = $urandom_range(8, 40);
            end else begin
                len = $urandom_range(1, 8);
            end
            // last run of a phase stops at the item budget
            if (len > n_items - sent)
                len = n_items - sent;
            repeat (len) begin
                if (kind >= 85) begin
                    op  = 1'($urandom_range(0, 1));
                    smp = t_sample'($urandom());
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        // jump past the threshold, either direction
                        v = int'(trig_thr) + 1 + int'($urandom_range(0, 500));
                        v = ($urandom_range(0, 1) != 0) ? base + v : base - v;
                        v = v * 256 + int'($urandom_range(0, 255));
                    end else begin
                        v = base + int'($urandom_range(0, 2 * spread)) - int'(spread);
                        v = v * 256 + int'($urandom_range(0, 255));
                    end
                    if (v > 8388607)
                        v = 8388607;
                    if (v < -8388608)
                        v = -8388608;
                    smp = t_sample'(v);
                end
                push_sample(op, smp, 1'b0, ST_RESET, '0);
                sent++;
            end
        end
    endtask

    // result side: random stalls, compare against oldest prediction
    initial begin : result_monitor
        t_judge_result want;
        int unsigned   stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(sink_quiet);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got status %0d average %0d",
                         $time, out_if.status, out_if.average);
            end else begin
                want = pending_results.pop_front();
                if (out_if.status !== want.status) begin
                    fail_count++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, out_if.status);
                end
                if (out_if.average !== want.average) begin
                    fail_count++;
                    $display("%0t: average expected %0d got %0d",
                             $time, want.average, out_if.average);
                end
            end
        end
    end

    // request side: reset, directed table, random phases
    initial begin : stimulus
        foreach (win_q8[j]) win_q8[j] = '0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_STILL_TO_MOVING;
        in_if.sample    <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset, extremes (mean truncates toward zero), fill, trigger,
        // updates after a trigger, early moving-to-still counting
        directed_rows = '{
            '{OP_STILL_TO_MOVING, 24'sh000000,  1, 1'b1, ST_RESET, 24'sd0},
            '{OP_STILL_TO_MOVING, 24'sh7FFFFF,  1, 1'b1, ST_RESET, 24'sd524287},
            '{OP_STILL_TO_MOVING, 24'sh800000,  1, 1'b1, ST_RESET, 24'sd0},
            '{OP_MOVING_TO_STILL, 24'sh7FFFFF,  1, 1'b1, ST_RESET, 24'sd0},
            '{OP_MOVING_TO_STILL, 24'sh800000,  1, 1'b1, ST_RESET, 24'sd0},
            '{OP_STILL_TO_MOVING, 24'sh000A80, 13, 1'b0, ST_RESET, 24'sd0},
            '{OP_STILL_TO_MOVING, 24'shFFFFFF,  1, 1'b0, ST_RESET, 24'sd0},
            '{OP_STILL_TO_MOVING, 24'sh7F0000,  1, 1'b0, ST_RESET, 24'sd0},
            '{OP_STILL_TO_MOVING, 24'sh000A80,  2, 1'b0, ST_RESET, 24'sd0},
            '{OP_MOVING_TO_STILL, 24'sh000100,  2, 1'b0, ST_RESET, 24'sd0}
        };
        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                push_sample(directed_rows[r].op, directed_rows[r].smp,
                            directed_rows[r].typed, directed_rows[r].status,
                            directed_rows[r].average);

        phase_thr = '{16'd0, 16'hFFFF, 16'd1, THRESH_RESET,
                      THRESH_W'($urandom_range(2, 40)),
                      THRESH_W'($urandom_range(0, 65535)),
                      THRESH_W'($urandom_range(2, 40)),
                      16'd10};
        foreach (phase_thr[p]) begin
            drain_and_set(phase_thr[p]);
            run_random(191);
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/wmd_pkg.sv
rtl/core/wmd_stream_if.sv
rtl/core/wmd_ram.sv
rtl/core/window_motion_detector.sv
verif/tb.sv
